// ===== rtl/sitpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitpd_pkg
// Shared constants for the signed integer to padded decimal text converter:
// parameter defaults, the field width register layout and the ASCII codes.
// ----------------------------------------------------------------------------
package sitpd_pkg;

  // Defaults for the top-level parameters.
  localparam int MaxFieldWidthDef = 32;
  localparam int ValueBitsDef     = 32;

  // Field width register: six bits, reset to eight characters.
  localparam int            FwBits  = 6;
  localparam logic [FwBits-1:0] FwReset = 6'd8;

  // Character codes.
  localparam int               CharBits   = 8;
  localparam logic [CharBits-1:0] CharZero  = 8'h30;
  localparam logic [CharBits-1:0] CharMinus = 8'h2D;
  localparam logic [CharBits-1:0] CharSpace = 8'h20;

endpackage

// ===== rtl/signed_int_to_padded_decimal.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal
// Converts one two's-complement integer to right-justified decimal ASCII
// text, one character per output transaction, most significant first.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                  Direction  Handshake
//  --------  -------------------------------------  ---------  ----------------
//  command   start_i, busy_o, value_i               in         start_i & !busy_o
//  result    out_valid_o, out_char_o, last_o        out        strobe, no stall
//  config    cfg_valid_i, cfg_ready_o, field_width_i in        valid & ready
//
//  Once a command is taken, the single shared shift-and-add-3 unit handles
//  one magnitude bit per cycle; then leading zero digits are dropped, keeping
//  at least one, and the first character is chosen. After that one character
//  leaves per cycle. busy_o stays high until the final character has been
//  registered. Reset clears the sequencer and sets the field width to eight.
//  The receiver cannot stall: each character is shown for one cycle.
//
module signed_int_to_padded_decimal #(
  parameter int MAX_FIELD_WIDTH = sitpd_pkg::MaxFieldWidthDef,
  parameter int VALUE_BITS      = sitpd_pkg::ValueBitsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Command channel.
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  // Result channel.
  output logic                                out_valid_o,
  output logic [sitpd_pkg::CharBits-1:0]      out_char_o,
  output logic                                last_o,
  // Configuration channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sitpd_pkg::FwBits-1:0]        field_width_i
);

  // Decimal digits of the largest magnitude, 2**(VALUE_BITS-1).
  localparam int NumDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BcdBits   = NumDigits * 4;
  localparam int BitCntW   = $clog2(VALUE_BITS);
  localparam int DigCntW   = $clog2(NumDigits + 1);
  localparam int WidW      = $clog2(MAX_FIELD_WIDTH + 1);
  localparam int CmpW      = ((WidW > sitpd_pkg::FwBits) ? WidW : sitpd_pkg::FwBits) + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CONV  = 6'b000010,
    ST_NORM  = 6'b000100,
    ST_PAD   = 6'b001000,
    ST_SIGN  = 6'b010000,
    ST_DIGIT = 6'b100000
  } state_e;

  state_e                          state_q, state_d;
  logic [VALUE_BITS-1:0]           bin_q, bin_d;
  logic [BcdBits-1:0]              bcd_q, bcd_d;
  logic [BcdBits-1:0]              bcd_adj;
  logic                            neg_q, neg_d;
  logic [BitCntW-1:0]              bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]              dig_cnt_q, dig_cnt_d;
  logic [CmpW-1:0]                 pad_q, pad_d;
  logic [sitpd_pkg::FwBits-1:0]    field_width_q;
  logic                            out_valid_q, out_valid_d;
  logic                            last_q, last_d;
  logic [sitpd_pkg::CharBits-1:0]  out_char_q, out_char_d;

  logic [VALUE_BITS-1:0]           raw;
  logic [3:0]                      top_digit;
  logic [CmpW-1:0]                 text_len;
  logic [CmpW-1:0]                 fw_ext;
  logic [CmpW-1:0]                 width_sat;

  assign raw       = value_i;
  assign top_digit = bcd_q[BcdBits-1 -: 4];

  // Always ready; write the register only when idle: the block does not check.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q <= sitpd_pkg::FwReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      field_width_q <= field_width_i;
    end
  end

  // Shared unit: add three to every BCD digit of five or more.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? (bcd_q[i*4 +: 4] + 4'd3)
                                                    : bcd_q[i*4 +: 4];
    end
  end

  // Text length and the field width limited to its maximum.
  assign text_len  = CmpW'(dig_cnt_q) + CmpW'(neg_q);
  assign fw_ext    = CmpW'(field_width_q);
  assign width_sat = (fw_ext > CmpW'(MAX_FIELD_WIDTH)) ? CmpW'(MAX_FIELD_WIDTH) : fw_ext;

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    neg_d       = neg_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    pad_d       = pad_q;
    out_valid_d = 1'b0;
    last_d      = 1'b0;
    out_char_d  = out_char_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          neg_d     = raw[VALUE_BITS-1];
          bin_d     = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(VALUE_BITS - 1);
          state_d   = ST_CONV;
        end
      end
      ST_CONV: begin
        // One magnitude bit enters the BCD register per cycle.
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DigCntW'(NumDigits);
          state_d   = ST_NORM;
        end else begin
          bit_cnt_d = bit_cnt_q - 1'b1;
        end
      end
      ST_NORM: begin
        // Drop leading zero digits, keeping at least one.
        if ((dig_cnt_q > DigCntW'(1)) && (top_digit == 4'd0)) begin
          bcd_d     = bcd_q << 4;
          dig_cnt_d = dig_cnt_q - 1'b1;
        end else if (width_sat > text_len) begin
          pad_d   = width_sat - text_len;
          state_d = ST_PAD;
        end else if (neg_q) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_PAD: begin
        out_valid_d = 1'b1;
        out_char_d  = sitpd_pkg::CharSpace;
        pad_d       = pad_q - 1'b1;
        if (pad_q == CmpW'(1)) begin
          state_d = neg_q ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        out_valid_d = 1'b1;
        out_char_d  = sitpd_pkg::CharMinus;
        state_d     = ST_DIGIT;
      end
      ST_DIGIT: begin
        out_valid_d = 1'b1;
        out_char_d  = sitpd_pkg::CharZero + {4'd0, top_digit};
        bcd_d       = bcd_q << 4;
        dig_cnt_d   = dig_cnt_q - 1'b1;
        if (dig_cnt_q == DigCntW'(1)) begin
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      neg_q       <= 1'b0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
      neg_q       <= neg_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    bit_cnt_q  <= bit_cnt_d;
    pad_q      <= pad_d;
    out_char_q <= out_char_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign last_o      = last_q;

  // Characters only follow a cycle in which a conversion was running.
  a_valid_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("character issued without a conversion in progress");

  // The final flag only ever comes with a character.
  a_last_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o)
    else $error("last flag without a character");

  // Nothing follows the final character of a number.
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |=> !out_valid_o)
    else $error("character issued after the final one");

  // The final character is always a digit.
  a_last_is_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (out_char_o >= sitpd_pkg::CharZero) &&
               (out_char_o <= sitpd_pkg::CharZero + 8'd9))
    else $error("final character is not a digit");

  // An accepted command starts a conversion.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not start a conversion");

endmodule

// ===== tb/sv/tb_signed_int_to_padded_decimal.sv =====
// ----------------------------------------------------------------------------
// tb_signed_int_to_padded_decimal
// Self-checking testbench for the signed integer to padded decimal text
// converter. A queue of numbers feeds a command driver, a predictor works out
// the padded text for each accepted number, and a monitor compares every
// character strobe with the oldest predicted character. The run steps through
// several field widths, the extremes among them, and several sender pacings.
// ----------------------------------------------------------------------------
module tb_signed_int_to_padded_decimal;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxWidth  = sitpd_pkg::MaxFieldWidthDef;
  localparam int ValueBits = sitpd_pkg::ValueBitsDef;

  // One character of converted text, as the block should present it.
  typedef struct packed {
    logic [sitpd_pkg::CharBits-1:0] ch;
    logic                           last;
  } text_char_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           start_i = 1'b0;
  logic                           busy_o;
  logic signed [ValueBits-1:0]    value_i = '0;
  logic                           out_valid_o;
  logic [sitpd_pkg::CharBits-1:0] out_char_o;
  logic                           last_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [sitpd_pkg::FwBits-1:0]   field_width_i = '0;

  // Numbers waiting to be sent, and text still owed by the block.
  logic [ValueBits-1:0] value_q[$];
  text_char_t           pending_text_q[$];

  logic [sitpd_pkg::FwBits-1:0] width_shadow = sitpd_pkg::FwReset;
  logic              cmd_taken = 1'b0;
  int unsigned       sender_idle_pct = 0;
  int unsigned       numbers_taken = 0;
  int unsigned       negatives_taken = 0;
  int unsigned       chars_checked = 0;
  int unsigned       error_count = 0;

  signed_int_to_padded_decimal uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_char_o    (out_char_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .field_width_i (field_width_i)
  );

  always #2 clk_i = ~clk_i;

  // Builds the right-justified text of one number and queues its characters.
  function automatic void format_decimal(input logic [ValueBits-1:0] raw,
                                         input logic [sitpd_pkg::FwBits-1:0] fw);
    logic                 neg;
    logic [ValueBits-1:0] mag;
    longint unsigned      rest;
    logic [3:0]           digits[20];
    int                   ndig;
    int                   width;
    int                   len;
    int                   total;
    int                   k;
    neg  = raw[ValueBits-1];
    // Negating in unsigned arithmetic keeps the most negative value exact.
    mag  = neg ? (~raw + 1'b1) : raw;
    rest = 64'(mag);
    ndig = 0;
    do begin
      digits[ndig] = 4'(rest % 10);
      ndig++;
      rest = rest / 10;
    end while (rest != 0);
    width = (int'(fw) > MaxWidth) ? MaxWidth : int'(fw);
    len   = ndig + int'(neg);
    total = (len > width) ? len : width;
    k     = 0;
    for (int i = 0; i < total - len; i++) begin
      pending_text_q.push_back('{ch: sitpd_pkg::CharSpace, last: (k + 1 == total)});
      k++;
    end
    if (neg) begin
      pending_text_q.push_back('{ch: sitpd_pkg::CharMinus, last: (k + 1 == total)});
      k++;
    end
    for (int i = ndig; i > 0; i--) begin
      pending_text_q.push_back('{ch: sitpd_pkg::CharZero + digits[i-1], last: (i == 1)});
    end
  endfunction

  // Mixes fully random numbers with small ones, decade boundaries and extremes.
  function automatic logic [ValueBits-1:0] random_value();
    int unsigned     pow10[10];
    int unsigned     pick;
    logic [ValueBits-1:0] v;
    pow10 = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000,
              1000000000};
    pick  = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: v = $urandom;
      4, 5: v = $urandom_range(0, 999);
      6, 7: begin
        v = pow10[$urandom_range(0, 9)];
        if ($urandom_range(0, 1) == 1) v = v - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(ValueBits-1){1'b0}}};
          1: v = {1'b0, {(ValueBits-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    if (pick >= 4 && pick <= 7 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Command driver: presents queued numbers at the falling edge, idling at
  // random, and holds start until the transaction is taken.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || cmd_taken) begin
      if (value_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        value_i <= value_q.pop_front();
        start_i <= 1'b1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predicts text on each accepted command and checks each strobe.
  always @(posedge clk_i) begin
    text_char_t exp_char;
    cmd_taken <= rst_ni && start_i && !busy_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) width_shadow = field_width_i;
      if (start_i && !busy_o) begin
        format_decimal(value_i, width_shadow);
        numbers_taken++;
        if (value_i < 0) negatives_taken++;
      end
      if (out_valid_o) begin
        if (pending_text_q.size() == 0) begin
          $display("%0t: unexpected character, expected none, got char %h last %b",
                   $time, out_char_o, last_o);
          error_count++;
        end else begin
          exp_char = pending_text_q.pop_front();
          chars_checked++;
          if (out_char_o !== exp_char.ch) begin
            $display("%0t: out_char mismatch, expected %h, got %h",
                     $time, exp_char.ch, out_char_o);
            error_count++;
          end
          if (last_o !== exp_char.last) begin
            $display("%0t: last mismatch, expected %b, got %b",
                     $time, exp_char.last, last_o);
            error_count++;
          end
        end
      end
    end
  end

  // Writes the field width register through its own channel.
  task automatic write_field_width(input logic [sitpd_pkg::FwBits-1:0] w);
    @(negedge clk_i);
    cfg_valid_i   <= 1'b1;
    field_width_i <= w;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Holds the stimulus back until every number has been sent and all of its
  // text has come out.
  task automatic wait_for_drain();
    while (value_q.size() != 0 || start_i || pending_text_q.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Queues a batch of random numbers with the given sender pacing.
  task automatic run_random_phase(input int count, input int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (count) value_q.push_back(random_value());
    wait_for_drain();
  endtask

  // Stimulus sequence: directed numbers at the reset width, then random
  // batches across the field width range. Each phase boundary also pauses
  // the sender until all outstanding text has arrived.
  initial begin
    logic signed [ValueBits-1:0] directed[$];
    directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -12345,
                 999999999, 1000000000, -1000000000, 2147483647, -2147483647,
                 32'sh8000_0000, 7, -7};
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed numbers with the reset width of eight characters.
    sender_idle_pct = 0;
    foreach (directed[i]) value_q.push_back(directed[i]);
    wait_for_drain();

    // Width zero behaves as one: no padding ever.
    write_field_width(6'd0);
    run_random_phase(20, 0);

    // All-ones width saturates at the maximum field.
    write_field_width(6'd63);
    run_random_phase(20, 74);

    write_field_width(MaxWidth[sitpd_pkg::FwBits-1:0]);
    run_random_phase(15, 15);

    // Exactly the widest signed text: sign plus ten digits.
    write_field_width(6'd11);
    run_random_phase(10, 74);

    write_field_width(6'd1);
    run_random_phase(10, 0);

    write_field_width(sitpd_pkg::FwBits'($urandom_range(0, 63)));
    run_random_phase(5, 15);

    repeat (100) @(negedge clk_i);
    $display("Converted %0d numbers (%0d negative) into %0d checked characters,",
             numbers_taken, negatives_taken, chars_checked);
    $display("over field widths 0 to 63 with steady and idling sender pacing.");
    if (error_count == 0 && pending_text_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (pending_text_q.size() != 0)
        $display("%0t: %0d characters expected but never seen",
                 $time, pending_text_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/sitpd_pkg.sv
rtl/signed_int_to_padded_decimal.sv
tb/sv/tb_signed_int_to_padded_decimal.sv
